// ===== hw/rtl/obhl_pkg.sv =====
`default_nettype none

package obhl_pkg;

  // Table geometry.
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Rotation unit sizing.
  localparam int TRIG_ITERATIONS = 16;
  localparam int ATAN_STEPS = 24;
  localparam int ITERS = (TRIG_ITERATIONS < ATAN_STEPS) ? TRIG_ITERATIONS : ATAN_STEPS;
  localparam int ITER_W = $clog2(ITERS);
  localparam int ATAN_IW = 5;

  localparam int CW = 24;             // coordinate width, Q15.8
  localparam int HW = 23;             // half extent width
  localparam int AW = 16;             // angle width
  localparam int DW = CW + 1;         // offset width
  localparam int XW = 36;             // rotated vector width
  localparam int ZW = 26;             // residual angle width, 2^-24 turn
  localparam int GW = 20;             // inverse gain width
  localparam int PW = XW + GW;        // product width

  localparam logic [GW-1:0] GAIN_INV = 20'd636751;
  localparam logic signed [AW-1:0] QUARTER_POS = 16'sd16384;
  localparam logic signed [AW-1:0] QUARTER_NEG = -16'sd16384;
  localparam logic signed [CW-1:0] MISS_HEIGHT = -24'sd256;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_ROT,
    S_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    R_IDLE,
    R_ROT,
    R_MULX,
    R_MULY,
    R_CMP
  } rot_state_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [HW-1:0]        hx;
    logic [HW-1:0]        hy;
    logic [AW-1:0]        angle;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [AW-1:0]        angle;
    logic [HW-1:0]        hx;
    logic [HW-1:0]        hy;
  } rot_req_t;

  typedef struct packed {
    logic done;
    logic in_box;
  } rot_rsp_t;

  // Arctangent of 2^-i in units of 2^-24 turn.
  function automatic logic [ZW-1:0] atan_lut(input logic [ATAN_IW-1:0] i);
    logic [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 26'd2097152;
      5'd1:  v = 26'd1238021;
      5'd2:  v = 26'd654136;
      5'd3:  v = 26'd332050;
      5'd4:  v = 26'd166669;
      5'd5:  v = 26'd83416;
      5'd6:  v = 26'd41718;
      5'd7:  v = 26'd20860;
      5'd8:  v = 26'd10430;
      5'd9:  v = 26'd5215;
      5'd10: v = 26'd2608;
      5'd11: v = 26'd1304;
      5'd12: v = 26'd652;
      5'd13: v = 26'd326;
      5'd14: v = 26'd163;
      5'd15: v = 26'd81;
      5'd16: v = 26'd41;
      5'd17: v = 26'd20;
      5'd18: v = 26'd10;
      5'd19: v = 26'd5;
      5'd20: v = 26'd3;
      5'd21: v = 26'd1;
      5'd22: v = 26'd1;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/obhl_cordic.sv =====
`default_nettype none

module obhl_cordic
  import obhl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rot_req_t req,
  output rot_rsp_t      rsp
);

  rot_state_t state_r, state_nxt;

  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [ITER_W-1:0]    i_r;
  logic [HW-1:0]        hx_r, hy_r;
  logic [PW-1:0]        prod_r;
  logic                 inx_r;

  logic [AW-1:0]        t_raw, t_fix;
  logic                 flip;
  logic signed [XW-1:0] x0, y0, xs, ys;
  logic [XW-1:0]        ax, ay, mul_a;
  logic [PW-1:0]        hx_lim, hy_lim;
  logic [ZW-1:0]        atan_v;

  // The target angle is minus the stored angle. Beyond a quarter turn the
  // vector is flipped and the angle moves by half a turn.
  assign t_raw = AW'(~req.angle + 1'b1);
  assign flip  = ($signed(t_raw) > QUARTER_POS) || ($signed(t_raw) < QUARTER_NEG);
  assign t_fix = flip ? {~t_raw[AW-1], t_raw[AW-2:0]} : t_raw;
  assign x0    = {{(XW-DW-8){req.dx[DW-1]}}, req.dx, 8'b0};
  assign y0    = {{(XW-DW-8){req.dy[DW-1]}}, req.dy, 8'b0};

  assign xs     = x_r >>> i_r;
  assign ys     = y_r >>> i_r;
  assign atan_v = atan_lut(ATAN_IW'(i_r));

  assign ax     = x_r[XW-1] ? XW'(-x_r) : XW'(x_r);
  assign ay     = y_r[XW-1] ? XW'(-y_r) : XW'(y_r);
  assign mul_a  = (state_r == R_MULX) ? ax : ay;
  assign hx_lim = PW'({hx_r, 28'b0});
  assign hy_lim = PW'({hy_r, 28'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rsp.done   = 1'b0;
    rsp.in_box = 1'b0;
    unique case (state_r)
      R_IDLE: begin
        if (req.start) begin
          state_nxt = R_ROT;
        end
      end
      R_ROT: begin
        if (i_r == ITER_W'(ITERS - 1)) begin
          state_nxt = R_MULX;
        end
      end
      R_MULX: state_nxt = R_MULY;
      R_MULY: state_nxt = R_CMP;
      R_CMP: begin
        rsp.done   = 1'b1;
        rsp.in_box = inx_r && (prod_r < hy_lim);
        state_nxt  = R_IDLE;
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == R_IDLE && req.start) begin
      x_r  <= flip ? -x0 : x0;
      y_r  <= flip ? -y0 : y0;
      z_r  <= {{(ZW-AW-8){t_fix[AW-1]}}, t_fix, 8'b0};
      i_r  <= '0;
      hx_r <= req.hx;
      hy_r <= req.hy;
    end else if (state_r == R_ROT) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - $signed(atan_v);
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + $signed(atan_v);
      end
      i_r <= i_r + 1'b1;
    end
    // One multiplier serves both axes, x first and then y.
    if (state_r == R_MULX || state_r == R_MULY) begin
      prod_r <= PW'(mul_a) * PW'(GAIN_INV);
    end
    if (state_r == R_MULY) begin
      inx_r <= prod_r < hx_lim;
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == R_IDLE)
    else $error("rotation started while the unit is busy");
  a_done_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(state_r) == R_MULY)
    else $error("rotation finished without the y product");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/oriented_box_height_lookup.sv =====
`default_nettype none

// Oriented box height lookup. The block holds up to sixteen rotated
// rectangles in insertion order. A load word appends one rectangle, or
// answers with status 1 when the table is full; a clear word empties it;
// a query word walks the table and returns the z of the first rectangle at
// or below the query height that contains the point, or found 0 with
// height -1.0. A query fetches the entries in order, skips each entry that
// lies above the point and tests each other entry with the sixteen CORDIC
// steps and two products of the single shared rotation unit. The block
// takes the next word while a finished result still waits on the output.
module oriented_box_height_lookup
  import obhl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_kind,
  input  wire logic signed [CW-1:0] in_coord_x,
  input  wire logic signed [CW-1:0] in_coord_y,
  input  wire logic signed [CW-1:0] in_coord_z,
  input  wire logic [HW-1:0]        in_half_x,
  input  wire logic [HW-1:0]        in_half_y,
  input  wire logic [AW-1:0]        in_angle,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_found,
  output logic signed [CW-1:0]      out_height,
  output logic                      out_status
);

  top_state_t state_r, state_nxt;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_r;
  entry_t wr_entry;

  logic [CNT_W-1:0]     count_r;
  logic [IDX_W-1:0]     idx_r;
  logic signed [CW-1:0] px_r, py_r, pz_r;
  logic                 res_found_r, res_status_r;
  logic signed [CW-1:0] res_height_r;
  logic                 out_valid_r, out_found_r, out_status_r;
  logic signed [CW-1:0] out_height_r;

  logic     accept, table_full, last_entry, skip, hit, advance, emit;
  logic     do_load, do_query, do_clear;
  rot_req_t rot_req;
  rot_rsp_t rot_rsp;

  assign accept     = in_valid && in_ready;
  assign table_full = (count_r >= CNT_W'(MAX_ENTRIES));
  assign last_entry = ((CNT_W'(idx_r) + 1'b1) == count_r);
  assign skip       = rd_r.z > pz_r;
  assign hit        = (state_r == S_ROT) && rot_rsp.done && rot_rsp.in_box;
  assign advance    = ((state_r == S_CHECK) && skip)
                   || ((state_r == S_ROT) && rot_rsp.done && !rot_rsp.in_box);
  assign emit       = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign wr_entry.x     = in_coord_x;
  assign wr_entry.y     = in_coord_y;
  assign wr_entry.z     = in_coord_z;
  assign wr_entry.hx    = in_half_x;
  assign wr_entry.hy    = in_half_y;
  assign wr_entry.angle = in_angle;

  assign rot_req.start = (state_r == S_CHECK) && !skip;
  assign rot_req.dx    = {px_r[CW-1], px_r} - {rd_r.x[CW-1], rd_r.x};
  assign rot_req.dy    = {py_r[CW-1], py_r} - {rd_r.y[CW-1], rd_r.y};
  assign rot_req.angle = rd_r.angle;
  assign rot_req.hx    = rd_r.hx;
  assign rot_req.hy    = rd_r.hy;

  obhl_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rot_req),
    .rsp   (rot_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    do_load   = 1'b0;
    do_query  = 1'b0;
    do_clear  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_kind)
            KIND_LOAD:  do_load  = 1'b1;
            KIND_QUERY: do_query = 1'b1;
            KIND_CLEAR: do_clear = 1'b1;
            default: ;
          endcase
          state_nxt = (do_query && count_r != '0) ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: state_nxt = S_CHECK;
      S_CHECK: begin
        if (!skip) begin
          state_nxt = S_ROT;
        end else begin
          state_nxt = last_entry ? S_DONE : S_FETCH;
        end
      end
      S_ROT: begin
        if (hit) begin
          state_nxt = S_DONE;
        end else if (advance) begin
          state_nxt = last_entry ? S_DONE : S_FETCH;
        end
      end
      S_DONE: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Entry table with a registered read port.
  always_ff @(posedge clk) begin
    if (do_load && !table_full) begin
      mem[count_r[IDX_W-1:0]] <= wr_entry;
    end
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (do_clear) begin
      count_r <= '0;
    end else if (do_load && !table_full) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r         <= in_coord_x;
      py_r         <= in_coord_y;
      pz_r         <= in_coord_z;
      idx_r        <= '0;
      res_found_r  <= 1'b0;
      res_height_r <= do_query ? MISS_HEIGHT : '0;
      res_status_r <= do_load && table_full;
    end else if (hit) begin
      res_found_r  <= 1'b1;
      res_height_r <= rd_r.z;
    end else if (advance) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_found_r  <= res_found_r;
      out_height_r <= res_height_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_height = out_height_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");
  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH || state_r == S_CHECK || state_r == S_ROT)
      |-> CNT_W'(idx_r) < count_r)
    else $error("table walk past the last valid entry");
  a_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
    rot_rsp.done |-> state_r == S_ROT)
    else $error("rotation result arrived outside a table walk");
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> !out_status_r)
    else $error("query hit reported together with a full table");
`endif

endmodule

`default_nettype wire
